>>> hw/rtl/dtw_pkg.sv
package dtw_pkg;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [0:0] CSR_BUFFER_LENGTH = 1'b0;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_ERROR   = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_LEN_COUNT = 2'd1;
   localparam logic [1:0] ERR_TRUNCATED = 2'd2;
   localparam logic [1:0] ERR_OVERRUN   = 2'd3;

   localparam logic [2:0] HDR_SATURATE = 3'd7;
   localparam logic [6:0] LONG_COUNT_MASK = 7'h7f;
   localparam logic [31:0] LEN_SHIFT_LIMIT = 32'h00ff_ffff;

   typedef enum logic [4:0] {
      PH_TAG     = 5'b00001,
      PH_LEN     = 5'b00010,
      PH_LONG    = 5'b00100,
      PH_CONTENT = 5'b01000,
      PH_HALT    = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [7:0]  tag_byte;
      logic [31:0] content_length;
      logic [2:0]  header_bytes;
      logic [31:0] element_offset;
      logic [1:0]  error_code;
      logic [31:0] item_count;
      logic        last_record;
   } record_type;

   typedef struct packed {
      logic       push0;
      logic       push1;
      record_type rec0;
      record_type rec1;
   } step_out_type;

   typedef struct packed {
      logic        restart;
      logic [31:0] length;
   } cfg_type;

endpackage

>>> hw/rtl/dtw_fifo.sv
module dtw_fifo
   import dtw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  step_out_type step,
   input  logic         pop,
   output logic         not_empty,
   output logic         has_room,
   output record_type   head
);

   record_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [FIFO_PTR_W-1:0] wr_ptr_next;
   logic                  do_pop;

   assign not_empty   = (count_ff != '0);
   assign has_room    = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign head        = mem_ff[rd_ptr_ff];
   assign do_pop      = pop && not_empty;
   assign wr_ptr_next = wr_ptr_ff + FIFO_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(step.push0) + FIFO_PTR_W'(step.push1);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(do_pop);
      count_in  = count_ff + FIFO_CNT_W'(step.push0) + FIFO_CNT_W'(step.push1)
                  - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.push0) begin
         mem_ff[wr_ptr_ff] <= step.rec0;
      end
      if (step.push1) begin
         mem_ff[wr_ptr_next] <= step.rec1;
      end
   end

   a_push_order: assert property (@(posedge clock) disable iff (reset)
      step.push1 |-> step.push0)
      else $error("second record pushed without first");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("record queue overflow");

endmodule

>>> hw/rtl/dtw_core.sv
module dtw_core
   import dtw_pkg::*;
#(
   parameter int unsigned MAX_LENGTH_BYTES = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic [31:0]  buffer_length,
   input  logic         fire,
   input  logic [7:0]   data_byte,
   output step_out_type step
);

   localparam int unsigned LEFT_W = $clog2(MAX_LENGTH_BYTES + 1);

   phase_type         phase_ff, phase_in;
   logic [31:0]       offset_ff, offset_in;
   logic [31:0]       bytes_left_ff, bytes_left_in;
   logic [LEFT_W-1:0] len_left_ff, len_left_in;
   logic [31:0]       acc_ff, acc_in;
   logic [31:0]       content_ff, content_in;
   logic [7:0]        tag_ff, tag_in;
   logic [31:0]       start_ff, start_in;
   logic [31:0]       total_ff, total_in;
   logic [1:0]        werr_ff, werr_in;

   logic        last;
   logic        err_hit;
   logic [1:0]  err_code;
   logic [2:0]  hdr;
   logic        finish;
   logic        hdr_ok;
   logic [6:0]  long_count;
   logic [31:0] span;
   record_type  main_rec;
   record_type  summary_rec;

   assign last       = (bytes_left_ff == 32'd1);
   assign long_count = data_byte[6:0] & LONG_COUNT_MASK;
   assign span       = offset_ff - start_ff;

   always_comb begin
      phase_in      = phase_ff;
      offset_in     = offset_ff;
      bytes_left_in = bytes_left_ff;
      len_left_in   = len_left_ff;
      acc_in        = acc_ff;
      content_in    = content_ff;
      tag_in        = tag_ff;
      start_in      = start_ff;
      total_in      = total_ff;
      werr_in       = werr_ff;
      err_hit       = 1'b0;
      err_code      = ERR_NONE;
      hdr           = 3'd0;
      finish        = 1'b0;
      hdr_ok        = 1'b0;

      if (fire && (bytes_left_ff != '0)) begin
         offset_in     = offset_ff + 32'd1;
         bytes_left_in = bytes_left_ff - 32'd1;
         case (phase_ff)
            PH_TAG: begin
               tag_in   = data_byte;
               start_in = offset_ff;
               acc_in   = '0;
               hdr      = 3'd1;
               if (last) begin
                  err_hit  = 1'b1;
                  err_code = ERR_TRUNCATED;
               end else begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               hdr = 3'd2;
               if (!data_byte[7]) begin
                  acc_in = {24'd0, data_byte};
                  finish = 1'b1;
               end else if ((long_count == '0) ||
                            (long_count > 7'(MAX_LENGTH_BYTES))) begin
                  err_hit  = 1'b1;
                  err_code = ERR_LEN_COUNT;
               end else if ({25'd0, long_count} >= bytes_left_ff) begin
                  err_hit  = 1'b1;
                  err_code = ERR_TRUNCATED;
               end else begin
                  len_left_in = long_count[LEFT_W-1:0];
                  acc_in      = '0;
                  phase_in    = PH_LONG;
               end
            end
            PH_LONG: begin
               if (acc_ff > LEN_SHIFT_LIMIT) begin
                  acc_in = '1;
               end else begin
                  acc_in = {acc_ff[23:0], data_byte};
               end
               len_left_in = len_left_ff - LEFT_W'(1);
               hdr = (span >= 32'd6) ? HDR_SATURATE : (span[2:0] + 3'd1);
               if (len_left_in == '0) begin
                  finish = 1'b1;
               end
            end
            PH_CONTENT: begin
               content_in = content_ff - 32'd1;
               if (content_in == '0) begin
                  phase_in = PH_TAG;
               end
            end
            default: begin
            end
         endcase

         if (finish) begin
            if (acc_in >= bytes_left_ff) begin
               err_hit  = 1'b1;
               err_code = ERR_OVERRUN;
            end else begin
               hdr_ok     = 1'b1;
               total_in   = total_ff + 32'd1;
               content_in = acc_in;
               phase_in   = (acc_in != '0) ? PH_CONTENT : PH_TAG;
            end
         end
         if (err_hit) begin
            werr_in  = err_code;
            phase_in = PH_HALT;
         end
      end

      if (cfg.restart) begin
         phase_in      = PH_TAG;
         offset_in     = '0;
         bytes_left_in = cfg.length;
         len_left_in   = '0;
         acc_in        = '0;
         content_in    = '0;
         tag_in        = '0;
         start_in      = '0;
         total_in      = '0;
         werr_in       = ERR_NONE;
      end
   end

   always_comb begin
      main_rec.record_kind    = err_hit ? KIND_ERROR : KIND_HEADER;
      main_rec.tag_byte       = tag_in;
      main_rec.content_length = (err_hit && (err_code != ERR_OVERRUN)) ? 32'd0 : acc_in;
      main_rec.header_bytes   = hdr;
      main_rec.element_offset = start_in;
      main_rec.error_code     = err_hit ? err_code : ERR_NONE;
      main_rec.item_count     = total_in;
      main_rec.last_record    = 1'b0;

      summary_rec.record_kind    = KIND_SUMMARY;
      summary_rec.tag_byte       = '0;
      summary_rec.content_length = '0;
      summary_rec.header_bytes   = '0;
      summary_rec.element_offset = buffer_length;
      summary_rec.error_code     = werr_in;
      summary_rec.item_count     = total_in;
      summary_rec.last_record    = 1'b1;

      step.push0 = 1'b0;
      step.push1 = 1'b0;
      step.rec0  = main_rec;
      step.rec1  = summary_rec;
      if (fire && (bytes_left_ff != '0)) begin
         if (err_hit || hdr_ok) begin
            step.push0 = 1'b1;
            step.push1 = last;
         end else if (last) begin
            step.push0 = 1'b1;
            step.rec0  = summary_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TAG;
         offset_ff     <= '0;
         bytes_left_ff <= '0;
         len_left_ff   <= '0;
         acc_ff        <= '0;
         content_ff    <= '0;
         tag_ff        <= '0;
         start_ff      <= '0;
         total_ff      <= '0;
         werr_ff       <= ERR_NONE;
      end else begin
         phase_ff      <= phase_in;
         offset_ff     <= offset_in;
         bytes_left_ff <= bytes_left_in;
         len_left_ff   <= len_left_in;
         acc_ff        <= acc_in;
         content_ff    <= content_in;
         tag_ff        <= tag_in;
         start_ff      <= start_in;
         total_ff      <= total_in;
         werr_ff       <= werr_in;
      end
   end

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HALT) |-> !(step.push0 && (step.rec0.record_kind != KIND_SUMMARY)))
      else $error("record other than summary after error");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      step.push1 |-> (step.rec1.last_record && (step.rec0.record_kind != KIND_SUMMARY)))
      else $error("second record is not the summary");

endmodule

>>> hw/rtl/der_tlv_stream_walker.sv
// channel   direction  handshake                     payload
// req_      in         req_valid / req_ready         req_data_byte
// rsp_      out        rsp_valid / rsp_ready         rsp_record_kind .. rsp_last_record
// csr_      in         csr_psel / csr_penable        csr_paddr, csr_pwdata, csr_prdata
//
// One byte is taken per cycle while the queue has room; the walk step sits between the
// input register and a four-record output queue; a byte is registered, then its record.
// The final buffer byte can yield two records, which drain one per cycle on rsp_ready.
// Reset is synchronous and clears the walk and buffer_length to zero.
// The input stalls only while the output queue has fewer than two free slots.
module der_tlv_stream_walker
   import dtw_pkg::*;
#(
   parameter int unsigned MAX_LENGTH_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_record_kind,
   output logic [7:0]  rsp_tag_byte,
   output logic [31:0] rsp_content_length,
   output logic [2:0]  rsp_header_bytes,
   output logic [31:0] rsp_element_offset,
   output logic [1:0]  rsp_error_code,
   output logic [31:0] rsp_item_count,
   output logic        rsp_last_record,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff, in_byte_in;
   logic [31:0]  buf_len_ff, buf_len_in;
   logic         fire;
   logic         has_room;
   cfg_type      cfg;
   step_out_type step;
   record_type   head;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_BUFFER_LENGTH) ? buf_len_ff : 32'd0;

   assign cfg.restart = csr_psel && csr_penable && csr_pwrite
                        && (csr_paddr[2] == CSR_BUFFER_LENGTH);
   assign cfg.length  = csr_pwdata;

   assign fire      = in_valid_ff && has_room;
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      buf_len_in  = buf_len_ff;
      if (fire) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
      end
      if (cfg.restart) begin
         buf_len_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         buf_len_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         buf_len_ff  <= buf_len_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   dtw_core #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .buffer_length (buf_len_ff),
      .fire          (fire),
      .data_byte     (in_byte_ff),
      .step          (step)
   );

   dtw_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .pop       (rsp_ready),
      .not_empty (rsp_valid),
      .has_room  (has_room),
      .head      (head)
   );

   assign rsp_record_kind    = head.record_kind;
   assign rsp_tag_byte       = head.tag_byte;
   assign rsp_content_length = head.content_length;
   assign rsp_header_bytes   = head.header_bytes;
   assign rsp_element_offset = head.element_offset;
   assign rsp_error_code     = head.error_code;
   assign rsp_item_count     = head.item_count;
   assign rsp_last_record    = head.last_record;

endmodule
